[src/laas_pkg.sv]
package laas_pkg;

  localparam int MAX_PATTERN = 512;
  localparam int MAX_TEXT    = 65536;

  localparam int SYM_W      = 8;
  localparam int CFG_W      = 8;
  localparam int SCORE_W    = 16;
  localparam int GAP_W      = 18;
  localparam int TEXT_IDX_W = 17;
  localparam int PAT_IDX_W  = 10;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int COL_W     = $clog2(MAX_PATTERN);
  localparam int PAT_CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int ROW_W     = $clog2(MAX_TEXT);
  localparam int TROW_W    = $clog2(MAX_TEXT + 1);

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TEXT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_OPEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXT  = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_ROW,
    OP_RED
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_REDUCE
  } st_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] match_reward;
    logic signed [CFG_W-1:0] mismatch_reward;
    logic [CFG_W-1:0]        gap_open_cost;
    logic [CFG_W-1:0]        gap_extend_cost;
  } cfg_t;

  // One word handed from a cell to its right neighbor.
  typedef struct packed {
    logic                    valid;
    op_t                     kind;
    logic [SYM_W-1:0]        sym;
    logic [SCORE_W-1:0]      h;      // H of left cell, or best value of a reduce token
    logic signed [GAP_W-1:0] e;      // E of left cell
    logic [SCORE_W-1:0]      diag;   // H of left cell in the previous row
    logic [ROW_W-1:0]        row;    // text row, or best row of a reduce token
    logic [COL_W-1:0]        col;    // column counter of a reduce token
    logic [COL_W-1:0]        bcol;   // best column of a reduce token
    logic                    found;
  } link_t;

endpackage

[src/laas_cell.sv]
module laas_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clr,
  input  laas_pkg::cfg_t  cfg,
  input  laas_pkg::link_t lnk_in,
  output laas_pkg::link_t lnk_out
);

  logic                                      act_r, act_nxt;
  logic [laas_pkg::SYM_W-1:0]                pat_r, pat_nxt;
  logic [laas_pkg::SCORE_W-1:0]              hup_r, hup_nxt;
  logic signed [laas_pkg::GAP_W-1:0]         fup_r, fup_nxt;
  logic [laas_pkg::SCORE_W-1:0]              bv_r, bv_nxt;
  logic [laas_pkg::ROW_W-1:0]                brow_r, brow_nxt;
  laas_pkg::link_t                           lnk_r, lnk_nxt;

  logic signed [laas_pkg::GAP_W-1:0] s_v, e_ext, e_opn, e_v, f_ext, f_opn, f_v;
  logic signed [laas_pkg::GAP_W-1:0] d_v, h_v;
  logic [laas_pkg::SCORE_W-1:0]      h16;
  logic                              take;

  // cell arithmetic for one matrix entry
  always_comb begin
    s_v   = (pat_r == lnk_in.sym) ?
            laas_pkg::GAP_W'(cfg.match_reward) : laas_pkg::GAP_W'(cfg.mismatch_reward);
    e_ext = lnk_in.e - $signed(laas_pkg::GAP_W'(cfg.gap_extend_cost));
    e_opn = $signed(laas_pkg::GAP_W'(lnk_in.h)) -
            $signed(laas_pkg::GAP_W'(cfg.gap_open_cost));
    e_v   = (e_opn > e_ext) ? e_opn : e_ext;
    f_ext = fup_r - $signed(laas_pkg::GAP_W'(cfg.gap_extend_cost));
    f_opn = $signed(laas_pkg::GAP_W'(hup_r)) -
            $signed(laas_pkg::GAP_W'(cfg.gap_open_cost));
    f_v   = (f_opn > f_ext) ? f_opn : f_ext;
    d_v   = $signed(laas_pkg::GAP_W'(lnk_in.diag)) + s_v;
    h_v   = d_v;
    if (e_v > h_v) h_v = e_v;
    if (f_v > h_v) h_v = f_v;
    if (h_v < 0) h_v = '0;
    if (h_v > $signed(laas_pkg::GAP_W'({laas_pkg::SCORE_W{1'b1}}))) begin
      h_v = laas_pkg::GAP_W'({laas_pkg::SCORE_W{1'b1}});
    end
    h16 = h_v[laas_pkg::SCORE_W-1:0];
  end

  // a column best wins on a larger value, or the same value in an earlier row
  assign take = act_r && (bv_r != '0) &&
                ((bv_r > lnk_in.h) || ((bv_r == lnk_in.h) && (brow_r < lnk_in.row)));

  always_comb begin
    act_nxt  = act_r;
    pat_nxt  = pat_r;
    hup_nxt  = hup_r;
    fup_nxt  = fup_r;
    bv_nxt   = bv_r;
    brow_nxt = brow_r;
    lnk_nxt  = lnk_in;
    if (lnk_in.valid) begin
      case (lnk_in.kind)
        laas_pkg::OP_LOAD: begin
          if (!act_r) begin
            act_nxt       = 1'b1;
            pat_nxt       = lnk_in.sym;
            lnk_nxt.valid = 1'b0;
          end
        end
        laas_pkg::OP_ROW: begin
          lnk_nxt.h    = h16;
          lnk_nxt.e    = e_v;
          lnk_nxt.diag = hup_r;
          hup_nxt      = h16;
          fup_nxt      = f_v;
          if (h16 > bv_r) begin
            bv_nxt   = h16;
            brow_nxt = lnk_in.row;
          end
        end
        laas_pkg::OP_RED: begin
          if (take) begin
            lnk_nxt.h     = bv_r;
            lnk_nxt.row   = brow_r;
            lnk_nxt.bcol  = lnk_in.col;
            lnk_nxt.found = 1'b1;
          end
          lnk_nxt.col = lnk_in.col + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      act_r <= 1'b0;
      hup_r <= '0;
      fup_r <= '0;
      bv_r  <= '0;
      lnk_r <= '0;
    end else begin
      act_r <= act_nxt;
      hup_r <= hup_nxt;
      fup_r <= fup_nxt;
      bv_r  <= bv_nxt;
      lnk_r <= lnk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r  <= pat_nxt;
    brow_r <= brow_nxt;
  end

  assign lnk_out = lnk_r;

endmodule

[src/local_alignment_affine_score.sv]
// Smith-Waterman local alignment score with affine (Gotoh) gaps, built as a
// systolic row of MAX_PATTERN cells, one per pattern column. A mode-0 word
// appends a pattern symbol, a mode-1 word computes one matrix row for a text
// symbol, and a mode-2 word finishes the pair: it returns the best score and
// its zero-based text and pattern end positions (0, -1, -1 when nothing
// scored) and clears the block for the next pair. Load and text words are
// taken one per cycle, back to back, while no finish is in progress; each
// moves one cell a cycle through the chain. A finish word sends a reduction
// token down the same chain right behind the last row, and the result word
// shows up once the token leaves the last cell; the input stalls until then,
// and a finish word also waits while an earlier result is still untaken.
// Pattern symbols past MAX_PATTERN, pattern symbols after the first text row,
// text rows past MAX_TEXT and mode 3 are taken and dropped. Configuration
// writes land at once and belong to idle periods.
module local_alignment_affine_score (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [laas_pkg::MODE_W-1:0]             in_mode,
  input  logic [laas_pkg::SYM_W-1:0]              in_symbol,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [laas_pkg::SCORE_W-1:0]            out_best_score,
  output logic signed [laas_pkg::TEXT_IDX_W-1:0]  out_end_text_index,
  output logic signed [laas_pkg::PAT_IDX_W-1:0]   out_end_pattern_index,
  input  logic                                    cfg_we,
  input  logic [laas_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [laas_pkg::CFG_W-1:0]              cfg_wdata
);

  laas_pkg::cfg_t                       cfg_r, cfg_nxt;
  laas_pkg::st_t                        state_r, state_nxt;
  logic [laas_pkg::PAT_CNT_W-1:0]       pat_cnt_r, pat_cnt_nxt;
  logic [laas_pkg::TROW_W-1:0]          text_row_r, text_row_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [laas_pkg::SCORE_W-1:0]         score_r, score_nxt;
  logic signed [laas_pkg::TEXT_IDX_W-1:0] tidx_r, tidx_nxt;
  logic signed [laas_pkg::PAT_IDX_W-1:0]  pidx_r, pidx_nxt;

  laas_pkg::link_t lnk [laas_pkg::MAX_PATTERN+1];
  laas_pkg::link_t tok;

  logic in_acc;
  logic done;
  logic clr;

  assign in_acc = in_valid && !in_stall;

  // Configuration registers: write at once, no read-back.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        laas_pkg::CFG_MATCH:    cfg_nxt.match_reward    = cfg_wdata;
        laas_pkg::CFG_MISMATCH: cfg_nxt.mismatch_reward = cfg_wdata;
        laas_pkg::CFG_GAP_OPEN: cfg_nxt.gap_open_cost   = cfg_wdata;
        laas_pkg::CFG_GAP_EXT:  cfg_nxt.gap_extend_cost = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Build the word that enters the first cell. Column zero of the matrix is
  // all zeros, so H, E and the diagonal enter as zero.
  always_comb begin
    lnk[0]      = '0;
    lnk[0].kind = laas_pkg::OP_ROW;
    lnk[0].sym  = in_symbol;
    lnk[0].row  = text_row_r[laas_pkg::ROW_W-1:0];
    if (in_acc) begin
      case (in_mode)
        laas_pkg::MODE_LOAD: begin
          lnk[0].kind  = laas_pkg::OP_LOAD;
          lnk[0].valid = (text_row_r == '0) &&
                         (pat_cnt_r < laas_pkg::PAT_CNT_W'(laas_pkg::MAX_PATTERN));
        end
        laas_pkg::MODE_TEXT: begin
          lnk[0].kind  = laas_pkg::OP_ROW;
          lnk[0].valid = (text_row_r < laas_pkg::TROW_W'(laas_pkg::MAX_TEXT));
        end
        laas_pkg::MODE_FINISH: begin
          // reduction token starts with value 0 and no position
          lnk[0].kind  = laas_pkg::OP_RED;
          lnk[0].row   = '0;
          lnk[0].valid = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < laas_pkg::MAX_PATTERN; g++) begin : g_cell
    laas_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clr     (clr),
      .cfg     (cfg_r),
      .lnk_in  (lnk[g]),
      .lnk_out (lnk[g+1])
    );
  end

  assign tok  = lnk[laas_pkg::MAX_PATTERN];
  assign done = tok.valid && (tok.kind == laas_pkg::OP_RED);

  // Pair counters: advance on kept words, drop back to zero when the pair ends.
  always_comb begin
    pat_cnt_nxt  = pat_cnt_r;
    text_row_nxt = text_row_r;
    if (lnk[0].valid && (lnk[0].kind == laas_pkg::OP_LOAD)) begin
      pat_cnt_nxt = pat_cnt_r + 1'b1;
    end
    if (lnk[0].valid && (lnk[0].kind == laas_pkg::OP_ROW)) begin
      text_row_nxt = text_row_r + 1'b1;
    end
    if (done) begin
      pat_cnt_nxt  = '0;
      text_row_nxt = '0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      laas_pkg::ST_IDLE: begin
        if (in_acc && (in_mode == laas_pkg::MODE_FINISH)) state_nxt = laas_pkg::ST_REDUCE;
      end
      laas_pkg::ST_REDUCE: begin
        if (done) state_nxt = laas_pkg::ST_IDLE;
      end
      default: state_nxt = laas_pkg::ST_IDLE;
    endcase
  end

  // Stall while the token runs or a held result blocks a finish; clear cells on exit.
  always_comb begin
    in_stall = 1'b0;
    clr      = 1'b0;
    case (state_r)
      laas_pkg::ST_IDLE: begin
        in_stall = out_valid_r && (in_mode == laas_pkg::MODE_FINISH);
      end
      laas_pkg::ST_REDUCE: begin
        in_stall = 1'b1;
        clr      = done;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Result register: load from the token, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    score_nxt     = score_r;
    tidx_nxt      = tidx_r;
    pidx_nxt      = pidx_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (done) begin
      out_valid_nxt = 1'b1;
      if (tok.found) begin
        score_nxt = tok.h;
        tidx_nxt  = laas_pkg::TEXT_IDX_W'(tok.row);
        pidx_nxt  = laas_pkg::PAT_IDX_W'(tok.bcol);
      end else begin
        score_nxt = '0;
        tidx_nxt  = '1;
        pidx_nxt  = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_reward    <= 8'sd1;
      cfg_r.mismatch_reward <= -8'sd1;
      cfg_r.gap_open_cost   <= 8'd2;
      cfg_r.gap_extend_cost <= 8'd1;
      state_r               <= laas_pkg::ST_IDLE;
      pat_cnt_r             <= '0;
      text_row_r            <= '0;
      out_valid_r           <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      state_r     <= state_nxt;
      pat_cnt_r   <= pat_cnt_nxt;
      text_row_r  <= text_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    tidx_r  <= tidx_nxt;
    pidx_r  <= pidx_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_best_score        = score_r;
  assign out_end_text_index    = tidx_r;
  assign out_end_pattern_index = pidx_r;

`ifndef NO_ASSERTIONS
  a_done_in_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (state_r == laas_pkg::ST_REDUCE))
    else $error("reduction token left the chain outside a finish");

  a_result_from_token: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(done))
    else $error("result word raised without a finished reduction");

  a_pair_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> ((pat_cnt_r == '0) && (text_row_r == '0)))
    else $error("pair counters not cleared after finish");

  a_pat_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pat_cnt_r <= laas_pkg::PAT_CNT_W'(laas_pkg::MAX_PATTERN))
    else $error("pattern count past the chain length");
`endif

endmodule
